// ===== sv/dawn_dusk_brightness_scheduler_defines.svh =====
// assertion macros used by the scheduler ramp divider rtl
`ifndef DAWN_DUSK_BRIGHTNESS_SCHEDULER_DEFINES_SVH
`define DAWN_DUSK_BRIGHTNESS_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS

`define DDBS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ddbs check failed");

`define DDBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ddbs check failed");

`else

`define DDBS_ASSERT_IMPL(label, clk, rst, ante, cons)

`define DDBS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/ddbs_pkg.sv =====
// shared types and constants of the brightness scheduler
package ddbs_pkg;

   localparam int HOUR_W   = 5;
   localparam int MIN_W    = 6;
   localparam int SEC_W    = 6;
   localparam int LEN_W    = 7;
   localparam int LEVEL_W  = 8;
   localparam int PHASE_W  = 3;
   localparam int STAMP_W  = 17;
   localparam int SPAN_W   = 13;
   localparam int REM_W    = SPAN_W + LEVEL_W;
   localparam int DIV_BITS = LEVEL_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   localparam logic [LEVEL_W-1:0] RAMP_FLOOR = 8'd10;
   localparam logic [STAMP_W-1:0] SECS_PER_MIN = 17'd60;
   localparam logic [STAMP_W-1:0] SECS_PER_HOUR = 17'd3600;

   localparam logic [PHASE_W-1:0] PHASE_OFF    = 3'd0;
   localparam logic [PHASE_W-1:0] PHASE_DAWN   = 3'd1;
   localparam logic [PHASE_W-1:0] PHASE_SUNSET = 3'd2;
   localparam logic [PHASE_W-1:0] PHASE_FULL   = 3'd3;
   localparam logic [PHASE_W-1:0] PHASE_FORCED = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_DAWN_HOUR   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DAWN_MINUTE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DAWN_LENGTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DUSK_HOUR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DUSK_MINUTE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_DUSK_LENGTH = 3'd5;

   typedef struct packed {
      logic [HOUR_W-1:0] dawn_start_hour;
      logic [MIN_W-1:0]  dawn_start_minute;
      logic [LEN_W-1:0]  dawn_length_minutes;
      logic [HOUR_W-1:0] dusk_start_hour;
      logic [MIN_W-1:0]  dusk_start_minute;
      logic [LEN_W-1:0]  dusk_length_minutes;
   } ddbs_cfg_type;

   typedef struct packed {
      logic [HOUR_W-1:0]  time_hour;
      logic [MIN_W-1:0]   time_minute;
      logic [SEC_W-1:0]   time_second;
      logic [LEVEL_W-1:0] peak_level;
      logic               schedule_on;
   } ddbs_item_type;

   // decided item heading into the ramp divider
   typedef struct packed {
      logic               vld;
      logic               is_ramp;
      logic               neg;
      logic [LEVEL_W-1:0] base;
      logic [LEVEL_W-1:0] mag;
      logic [SPAN_W-1:0]  em1;
      logic [SPAN_W-1:0]  den;
      logic [PHASE_W-1:0] phase;
   } ddbs_ramp_type;

   typedef struct packed {
      logic               vld;
      logic [LEVEL_W-1:0] duty_level;
      logic [PHASE_W-1:0] light_phase;
   } ddbs_out_type;

endpackage

// ===== sv/ddbs_if.sv =====
// request and response stream interfaces
interface ddbs_req_if;
   import ddbs_pkg::*;
   logic               valid;
   logic               ready;
   logic [HOUR_W-1:0]  time_hour;
   logic [MIN_W-1:0]   time_minute;
   logic [SEC_W-1:0]   time_second;
   logic [LEVEL_W-1:0] peak_level;
   logic               schedule_on;

   modport source (output valid, time_hour, time_minute, time_second, peak_level,
                   schedule_on, input ready);
   modport sink (input valid, time_hour, time_minute, time_second, peak_level,
                 schedule_on, output ready);
endinterface

interface ddbs_rsp_if;
   import ddbs_pkg::*;
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] duty_level;
   logic [PHASE_W-1:0] light_phase;

   modport source (output valid, duty_level, light_phase, input ready);
   modport sink (input valid, duty_level, light_phase, output ready);
endinterface

// ===== sv/ddbs_front.sv =====
// time stamp stage and window decision stage
module ddbs_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  ddbs_pkg::ddbs_cfg_type cfg,
   input  logic                   in_vld,
   input  ddbs_pkg::ddbs_item_type item,
   output ddbs_pkg::ddbs_ramp_type ramp_out
);
   import ddbs_pkg::*;

   typedef struct packed {
      logic               vld;
      logic               sched;
      logic [LEVEL_W-1:0] peak;
      logic [STAMP_W-1:0] now;
      logic [STAMP_W-1:0] dawn_t;
      logic [STAMP_W-1:0] dusk_t;
   } ddbs_stamp_type;

   ddbs_stamp_type s1_ff, s1_in;
   ddbs_ramp_type  s2_ff, s2_in;

   logic               dawn_lt, dusk_lt, in_dawn, in_dusk;
   logic [STAMP_W-1:0] e_dawn, e_dusk, dawn_span, dusk_span;
   logic [LEVEL_W-1:0] abs_diff;
   logic               peak_low, peak_high;

   // stage 1: seconds since midnight
   always_comb begin
      s1_in.vld    = in_vld;
      s1_in.sched  = item.schedule_on;
      s1_in.peak   = item.peak_level;
      s1_in.now    = STAMP_W'(item.time_hour) * SECS_PER_HOUR
                   + STAMP_W'(item.time_minute) * SECS_PER_MIN
                   + STAMP_W'(item.time_second);
      s1_in.dawn_t = STAMP_W'(cfg.dawn_start_hour) * SECS_PER_HOUR
                   + STAMP_W'(cfg.dawn_start_minute) * SECS_PER_MIN;
      s1_in.dusk_t = STAMP_W'(cfg.dusk_start_hour) * SECS_PER_HOUR
                   + STAMP_W'(cfg.dusk_start_minute) * SECS_PER_MIN;
   end

   always_ff @(posedge clock) begin
      if (reset) s1_ff.vld <= 1'b0;
      else if (adv) s1_ff <= s1_in;
   end

   // stage 2: which window, ramp operands
   always_comb begin
      dawn_span = STAMP_W'(cfg.dawn_length_minutes) * SECS_PER_MIN;
      dusk_span = STAMP_W'(cfg.dusk_length_minutes) * SECS_PER_MIN;
      dawn_lt   = s1_ff.dawn_t < s1_ff.now;
      dusk_lt   = s1_ff.dusk_t < s1_ff.now;
      e_dawn    = s1_ff.now - s1_ff.dawn_t;
      e_dusk    = s1_ff.now - s1_ff.dusk_t;
      in_dawn   = e_dawn < dawn_span;
      in_dusk   = e_dusk < dusk_span;
      peak_low  = s1_ff.peak < RAMP_FLOOR;
      peak_high = s1_ff.peak > RAMP_FLOOR;
      abs_diff  = peak_low ? (RAMP_FLOOR - s1_ff.peak) : (s1_ff.peak - RAMP_FLOOR);

      s2_in.vld     = s1_ff.vld;
      s2_in.is_ramp = 1'b0;
      s2_in.neg     = 1'b0;
      s2_in.base    = '0;
      s2_in.mag     = '0;
      s2_in.em1     = '0;
      s2_in.den     = '0;
      s2_in.phase   = PHASE_OFF;
      if (!s1_ff.sched) begin
         s2_in.base  = s1_ff.peak;
         s2_in.phase = PHASE_FORCED;
      end else if (!dawn_lt) begin
         s2_in.phase = PHASE_OFF;
      end else if (in_dawn) begin
         s2_in.is_ramp = 1'b1;
         s2_in.neg     = peak_low;
         s2_in.base    = RAMP_FLOOR;
         s2_in.mag     = abs_diff;
         s2_in.em1     = e_dawn[SPAN_W-1:0] - SPAN_W'(1);
         s2_in.den     = dawn_span[SPAN_W-1:0] - SPAN_W'(1);
         s2_in.phase   = PHASE_DAWN;
      end else if (!dusk_lt) begin
         s2_in.base  = s1_ff.peak;
         s2_in.phase = PHASE_FULL;
      end else if (in_dusk) begin
         s2_in.is_ramp = 1'b1;
         s2_in.neg     = peak_high;
         s2_in.base    = s1_ff.peak;
         s2_in.mag     = abs_diff;
         s2_in.em1     = e_dusk[SPAN_W-1:0] - SPAN_W'(1);
         s2_in.den     = dusk_span[SPAN_W-1:0] - SPAN_W'(1);
         s2_in.phase   = PHASE_SUNSET;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s2_ff.vld <= 1'b0;
      else if (adv) s2_ff <= s2_in;
   end

   assign ramp_out = s2_ff;

endmodule

// ===== sv/ddbs_ramp_div.sv =====
// ramp product stage, bit-per-stage divider and output register
`include "dawn_dusk_brightness_scheduler_defines.svh"

module ddbs_ramp_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  ddbs_pkg::ddbs_ramp_type ramp_in,
   output ddbs_pkg::ddbs_out_type  out
);
   import ddbs_pkg::*;

   typedef struct packed {
      logic               vld;
      logic               is_ramp;
      logic               neg;
      logic [LEVEL_W-1:0] base;
      logic [PHASE_W-1:0] phase;
      logic [SPAN_W-1:0]  den;
      logic [REM_W-1:0]   rem;
      logic [LEVEL_W-1:0] quo;
   } ddbs_div_type;

   ddbs_div_type st_ff [DIV_BITS+1];
   ddbs_div_type st_in [DIV_BITS+1];
   ddbs_div_type fin;
   ddbs_out_type out_ff, out_in;

   // stage 0: numerator (e-1)*|b-a|
   always_comb begin
      st_in[0].vld     = ramp_in.vld;
      st_in[0].is_ramp = ramp_in.is_ramp;
      st_in[0].neg     = ramp_in.neg;
      st_in[0].base    = ramp_in.base;
      st_in[0].phase   = ramp_in.phase;
      st_in[0].den     = ramp_in.den;
      st_in[0].rem     = REM_W'(ramp_in.em1) * REM_W'(ramp_in.mag);
      st_in[0].quo     = '0;
   end

   // one quotient bit per stage, msb first; quotient stays below 2**DIV_BITS
   for (genvar i = 1; i <= DIV_BITS; i++) begin : g_div
      logic [REM_W-1:0] sub_val;
      logic             take;
      always_comb begin
         sub_val  = REM_W'(st_ff[i-1].den) << (DIV_BITS - i);
         take     = st_ff[i-1].is_ramp && (st_ff[i-1].rem >= sub_val);
         st_in[i] = st_ff[i-1];
         if (take) begin
            st_in[i].rem              = st_ff[i-1].rem - sub_val;
            st_in[i].quo[DIV_BITS-i]  = 1'b1;
         end
      end
   end

   for (genvar i = 0; i <= DIV_BITS; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) st_ff[i].vld <= 1'b0;
         else if (adv) st_ff[i] <= st_in[i];
      end
   end

   assign fin = st_ff[DIV_BITS];

   // apply sign of the ramp, truncated toward zero
   always_comb begin
      out_in.vld         = fin.vld;
      out_in.light_phase = fin.phase;
      out_in.duty_level  = fin.neg ? (fin.base - fin.quo) : (fin.base + fin.quo);
   end

   always_ff @(posedge clock) begin
      if (reset) out_ff.vld <= 1'b0;
      else if (adv) out_ff <= out_in;
   end

   assign out = out_ff;

   `DDBS_ASSERT_IMPL(a_rem_below_den, clock, reset, fin.vld && fin.is_ramp, fin.rem < REM_W'(fin.den))
   `DDBS_ASSERT_IMPL(a_flat_no_quo, clock, reset, fin.vld && !fin.is_ramp, fin.quo == '0)
   `DDBS_ASSERT_IMPL(a_off_is_dark, clock, reset, out_ff.vld && (out_ff.light_phase == PHASE_OFF), out_ff.duty_level == '0)
   `DDBS_ASSERT_NEXT(a_valid_moves, clock, reset, adv && st_ff[0].vld, st_ff[1].vld)

endmodule

// ===== sv/dawn_dusk_brightness_scheduler.sv =====
// top level of the dawn and dusk brightness scheduler
// One item in, one item out. The block is a 12-stage pipeline: seconds-since-
// midnight stamps, window decision, ramp product, eight restoring divider
// stages (one quotient bit each) and an output register. It takes one item
// every cycle when the output side does not stall, and a stall on the output
// freezes the whole pipeline. The ramp level is (e-1)*(b-a)/(len*60-1)+a
// truncated toward zero; phase is 0 off, 1 dawn, 2 sunset, 3 full, 4 forced.
// Registers should only be written while no items are in flight.
module dawn_dusk_brightness_scheduler (
   input  logic                               clock,
   input  logic                               reset,
   ddbs_req_if.sink                           req_if,
   ddbs_rsp_if.source                         rsp_if,
   input  logic                               csr_wr_en,
   input  logic [ddbs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ddbs_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ddbs_pkg::*;

   ddbs_cfg_type  cfg_ff, cfg_in;
   ddbs_item_type item;
   ddbs_ramp_type ramp;
   ddbs_out_type  out;
   logic          adv;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_DAWN_HOUR:   cfg_in.dawn_start_hour     = csr_wdata[HOUR_W-1:0];
            REG_DAWN_MINUTE: cfg_in.dawn_start_minute   = csr_wdata[MIN_W-1:0];
            REG_DAWN_LENGTH: cfg_in.dawn_length_minutes = csr_wdata[LEN_W-1:0];
            REG_DUSK_HOUR:   cfg_in.dusk_start_hour     = csr_wdata[HOUR_W-1:0];
            REG_DUSK_MINUTE: cfg_in.dusk_start_minute   = csr_wdata[MIN_W-1:0];
            REG_DUSK_LENGTH: cfg_in.dusk_length_minutes = csr_wdata[LEN_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dawn_start_hour     <= 5'd7;
         cfg_ff.dawn_start_minute   <= 6'd0;
         cfg_ff.dawn_length_minutes <= 7'd30;
         cfg_ff.dusk_start_hour     <= 5'd19;
         cfg_ff.dusk_start_minute   <= 6'd0;
         cfg_ff.dusk_length_minutes <= 7'd30;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // whole pipeline moves unless a finished item is held at the output
   assign adv = !out.vld || rsp_if.ready;
   assign req_if.ready = adv;

   always_comb begin
      item.time_hour   = req_if.time_hour;
      item.time_minute = req_if.time_minute;
      item.time_second = req_if.time_second;
      item.peak_level  = req_if.peak_level;
      item.schedule_on = req_if.schedule_on;
   end

   ddbs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .cfg      (cfg_ff),
      .in_vld   (req_if.valid),
      .item     (item),
      .ramp_out (ramp)
   );

   ddbs_ramp_div u_ramp_div (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .ramp_in (ramp),
      .out     (out)
   );

   assign rsp_if.valid       = out.vld;
   assign rsp_if.duty_level  = out.duty_level;
   assign rsp_if.light_phase = out.light_phase;

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the dawn and dusk brightness scheduler
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ddbs_pkg::*;

   localparam int PIPE_DEPTH = 12;
   localparam int SECS_MIN   = 60;
   localparam int SECS_HOUR  = 3600;

   typedef struct {
      logic [LEVEL_W-1:0] duty;
      logic [PHASE_W-1:0] phase;
   } lamp_type;

   class schedule_tracker_type;
      ddbs_cfg_type cfg;
      lamp_type     pending_levels[$];
      int           errors;

      function new();
         cfg.dawn_start_hour     = 5'd7;
         cfg.dawn_start_minute   = 6'd0;
         cfg.dawn_length_minutes = 7'd30;
         cfg.dusk_start_hour     = 5'd19;
         cfg.dusk_start_minute   = 6'd0;
         cfg.dusk_length_minutes = 7'd30;
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_DAWN_HOUR:   cfg.dawn_start_hour     = val[HOUR_W-1:0];
            REG_DAWN_MINUTE: cfg.dawn_start_minute   = val[MIN_W-1:0];
            REG_DAWN_LENGTH: cfg.dawn_length_minutes = val[LEN_W-1:0];
            REG_DUSK_HOUR:   cfg.dusk_start_hour     = val[HOUR_W-1:0];
            REG_DUSK_MINUTE: cfg.dusk_start_minute   = val[MIN_W-1:0];
            REG_DUSK_LENGTH: cfg.dusk_length_minutes = val[LEN_W-1:0];
            default: ;
         endcase
      endfunction

      function int dawn_secs();
         return int'(cfg.dawn_start_hour) * SECS_HOUR + int'(cfg.dawn_start_minute) * SECS_MIN;
      endfunction

      function int dusk_secs();
         return int'(cfg.dusk_start_hour) * SECS_HOUR + int'(cfg.dusk_start_minute) * SECS_MIN;
      endfunction

      // signed division truncates toward zero, as the ramp requires
      function int ramp_level(int el, int len, int lo, int hi);
         return (el - 1) * (hi - lo) / (len * SECS_MIN - 1) + lo;
      endfunction

      function lamp_type schedule_duty(ddbs_item_type it);
         lamp_type r;
         int       now;
         int       el;
         int       len;
         int       peak;
         int       floor_lvl;
         peak      = int'(it.peak_level);
         floor_lvl = int'(RAMP_FLOOR);
         r.duty    = '0;
         r.phase   = PHASE_OFF;
         if (!it.schedule_on) begin
            r.duty  = it.peak_level;
            r.phase = PHASE_FORCED;
            return r;
         end
         now = (int'(it.time_hour) * SECS_MIN + int'(it.time_minute)) * SECS_MIN
               + int'(it.time_second);
         if (now > dawn_secs()) begin
            el  = now - dawn_secs();
            len = int'(cfg.dawn_length_minutes);
            if (el / SECS_MIN < len) begin
               r.duty  = LEVEL_W'(ramp_level(el, len, floor_lvl, peak));
               r.phase = PHASE_DAWN;
            end else if (now > dusk_secs()) begin
               el  = now - dusk_secs();
               len = int'(cfg.dusk_length_minutes);
               if (el / SECS_MIN < len) begin
                  r.duty  = LEVEL_W'(ramp_level(el, len, peak, floor_lvl));
                  r.phase = PHASE_SUNSET;
               end
            end else begin
               r.duty  = it.peak_level;
               r.phase = PHASE_FULL;
            end
         end
         return r;
      endfunction

      function void note_item(ddbs_item_type it);
         pending_levels.push_back(schedule_duty(it));
      endfunction

      function void check_result(logic [LEVEL_W-1:0] duty, logic [PHASE_W-1:0] phase);
         lamp_type want;
         if (pending_levels.size() == 0) begin
            $error("unexpected result item duty_level %0d light_phase %0d", duty, phase);
            errors++;
            return;
         end
         want = pending_levels.pop_front();
         if (duty !== want.duty) begin
            $error("duty_level expected %0d actual %0d", want.duty, duty);
            errors++;
         end
         if (phase !== want.phase) begin
            $error("light_phase expected %0d actual %0d", want.phase, phase);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   bit                    calm;

   ddbs_req_if req_bus ();
   ddbs_rsp_if rsp_bus ();

   schedule_tracker_type sb;

   dawn_dusk_brightness_scheduler u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("dawn_dusk_brightness_scheduler verification failed");
      $finish;
   end

   // output back-pressure in random bursts
   initial begin
      int burst;
      burst = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (burst > 0) begin
            burst--;
            rsp_bus.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 10) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         sb.check_result(rsp_bus.duty_level, rsp_bus.light_phase);
   end

   function automatic ddbs_item_type make_item(int h, int m, int s, int peak, bit on);
      ddbs_item_type it;
      it.time_hour   = HOUR_W'(h);
      it.time_minute = MIN_W'(m);
      it.time_second = SEC_W'(s);
      it.peak_level  = LEVEL_W'(peak);
      it.schedule_on = on;
      return it;
   endfunction

   // mostly times around the two windows, the rest raw field values
   function automatic ddbs_item_type roll_item();
      ddbs_item_type it;
      int            pick;
      int            anchor;
      int            span;
      int            now;
      pick = $urandom_range(0, 9);
      it.time_hour   = HOUR_W'($urandom_range(0, 31));
      it.time_minute = MIN_W'($urandom_range(0, 63));
      it.time_second = SEC_W'($urandom_range(0, 63));
      it.peak_level  = ($urandom_range(0, 7) == 0) ? LEVEL_W'($urandom_range(0, 12))
                                                   : LEVEL_W'($urandom_range(0, 255));
      it.schedule_on = ($urandom_range(0, 9) != 0);
      if (pick < 8) begin
         if (pick[0]) begin
            anchor = sb.dawn_secs();
            span   = int'(sb.cfg.dawn_length_minutes) * SECS_MIN;
         end else begin
            anchor = sb.dusk_secs();
            span   = int'(sb.cfg.dusk_length_minutes) * SECS_MIN;
         end
         if (pick < 2) begin
            case ($urandom_range(0, 5))
               0: now = anchor;
               1: now = anchor + 1;
               2: now = anchor + 2;
               3: now = anchor + span - 1;
               4: now = anchor + span;
               default: now = anchor + span + 1;
            endcase
         end else begin
            now = anchor - 120 + $urandom_range(0, span + 240);
         end
         if (now < 0)
            now = 0;
         if (now / SECS_HOUR <= 31) begin
            it.time_hour   = HOUR_W'(now / SECS_HOUR);
            it.time_minute = MIN_W'((now % SECS_HOUR) / SECS_MIN);
            it.time_second = SEC_W'(now % SECS_MIN);
         end
      end
      return it;
   endfunction

   // called and returns at a falling edge
   task automatic push_item(input ddbs_item_type it);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.time_hour   <= it.time_hour;
      req_bus.time_minute <= it.time_minute;
      req_bus.time_second <= it.time_second;
      req_bus.peak_level  <= it.peak_level;
      req_bus.schedule_on <= it.schedule_on;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_item(it);
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.pending_levels.size() != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      @(posedge clock);
      sb.set_reg(idx, CSR_DATA_W'(val));
      @(negedge clock);
   endtask

   task automatic run_schedule(input int dh, input int dm, input int dl, input int sh,
                               input int sm, input int sl, input int count, input bit quiet);
      drain();
      write_reg(REG_DAWN_HOUR, dh);
      write_reg(REG_DAWN_MINUTE, dm);
      write_reg(REG_DAWN_LENGTH, dl);
      write_reg(REG_DUSK_HOUR, sh);
      write_reg(REG_DUSK_MINUTE, sm);
      write_reg(REG_DUSK_LENGTH, sl);
      csr_wr_en <= 1'b0;
      calm = quiet;
      repeat (count) push_item(roll_item());
   endtask

   initial begin
      sb   = new();
      calm = 1'b0;
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_index           <= '0;
      csr_wdata           <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.time_hour   <= '0;
      req_bus.time_minute <= '0;
      req_bus.time_second <= '0;
      req_bus.peak_level  <= '0;
      req_bus.schedule_on <= 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed items against the power-on schedule
      push_item(make_item(31, 63, 63, 0, 1'b0));
      push_item(make_item(31, 63, 63, 255, 1'b0));
      push_item(make_item(0, 0, 0, 200, 1'b1));
      push_item(make_item(7, 0, 0, 255, 1'b1));
      push_item(make_item(7, 0, 1, 255, 1'b1));
      push_item(make_item(7, 15, 0, 255, 1'b1));
      push_item(make_item(7, 29, 59, 255, 1'b1));
      push_item(make_item(7, 30, 0, 128, 1'b1));
      push_item(make_item(7, 10, 0, 3, 1'b1));
      push_item(make_item(12, 0, 0, 0, 1'b1));
      push_item(make_item(19, 0, 0, 200, 1'b1));
      push_item(make_item(19, 0, 1, 200, 1'b1));
      push_item(make_item(19, 29, 59, 200, 1'b1));
      push_item(make_item(19, 15, 30, 0, 1'b1));
      push_item(make_item(19, 20, 0, 5, 1'b1));
      push_item(make_item(19, 30, 0, 200, 1'b1));
      push_item(make_item(23, 59, 59, 255, 1'b1));
      push_item(make_item(31, 63, 63, 255, 1'b1));
      push_item(make_item(7, 63, 63, 100, 1'b1));

      run_schedule(0, 0, 15, 23, 59, 120, 125, 1'b0);
      run_schedule(31, 63, 127, 31, 63, 127, 125, 1'b0);
      // zero-length windows are skipped
      run_schedule(6, 30, 0, 18, 45, 0, 125, $urandom_range(0, 3) == 0);
      // sunset starts inside the dawn window
      run_schedule(8, 0, 120, 8, 30, 60, 125, 1'b0);
      // sunset already over when dawn ends
      run_schedule(12, 0, 45, 10, 0, 30, 125, $urandom_range(0, 3) == 0);
      run_schedule(5, 15, 1, 20, 10, 1, 125, 1'b0);
      run_schedule($urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 127),
                   $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 127),
                   125, 1'b0);
      run_schedule(7, 0, 30, 19, 0, 30, 125, 1'b0);
      run_schedule(3, 45, 90, 16, 15, 105, 125, 1'b1);

      drain();
      if (sb.errors == 0 && sb.pending_levels.size() == 0) begin
         $display("dawn_dusk_brightness_scheduler verification clean");
      end else begin
         $display("dawn_dusk_brightness_scheduler verification failed");
      end
      $finish;
   end

endmodule
